>>> sv/zsbr_pkg.sv
// ----------------------------------------------------------------------------
// zsbr_pkg
// Shared types and constants for the zero-stuffed sine biquad reconstruction
// block: word widths, sequencer states, sine table and DAC conversion values.
// ----------------------------------------------------------------------------
package zsbr_pkg;

  localparam int COEF_W     = 16;
  localparam int HIST_W     = 24;
  localparam int PROD_W     = COEF_W + HIST_W;
  localparam int ACC_W      = PROD_W + 3;
  localparam int FRAC_SHIFT = 14;
  localparam int SAMPLE_W   = 16;
  localparam int DAC_W      = 12;
  localparam int TABLE_LEN  = 8;
  localparam int TAPS       = 5;
  localparam int HIST_PER   = 4;

  localparam logic ACTION_TICK = 1'b0;
  localparam logic ACTION_LOAD = 1'b1;

  localparam logic signed [SAMPLE_W:0] DAC_OFFSET = 17'sd10000;
  localparam logic [15:0]              RECIP5     = 16'd52429;
  localparam int                       RECIP5_SH  = 18;
  localparam logic [DAC_W-1:0]         DAC_MAX    = 12'd4095;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN,
    ST_EMIT
  } seq_state_t;

  function automatic logic signed [SAMPLE_W-1:0] wave_lookup(input logic [2:0] pos);
    logic signed [SAMPLE_W-1:0] v;
    case (pos)
      3'd0:    v = 16'sd0;
      3'd1:    v = 16'sd7071;
      3'd2:    v = 16'sd10000;
      3'd3:    v = 16'sd7071;
      3'd4:    v = 16'sd0;
      3'd5:    v = -16'sd7071;
      3'd6:    v = -16'sd10000;
      3'd7:    v = -16'sd7071;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/zero_stuffed_sine_biquad_recon.sv
// ----------------------------------------------------------------------------
// zero_stuffed_sine_biquad_recon
// A tick word runs ST_RUN for each section, then ST_FIN and ST_EMIT, where its
// result is registered once the output is free; a coefficient load gives none.
// Words are taken only in ST_IDLE, so no tick is taken before the last result;
// sections share one multiply-accumulate unit and history memory (8 steps each).
// Reset clears counters, ratio (to 6), valid bits of coefficients and history.
// ----------------------------------------------------------------------------
module zero_stuffed_sine_biquad_recon #(
  parameter int SECTIONS = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_action,
  input  logic [5:0]                            in_coef_index,
  input  logic signed [zsbr_pkg::COEF_W-1:0]    in_coef_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [zsbr_pkg::SAMPLE_W-1:0]  out_filtered_sample,
  output logic [zsbr_pkg::DAC_W-1:0]            out_dac_code,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [3:0]                            cfg_data
);

  localparam int CDEPTH = zsbr_pkg::TAPS * SECTIONS;
  localparam int HDEPTH = zsbr_pkg::HIST_PER * SECTIONS;
  localparam int CAW    = $clog2(CDEPTH);
  localparam int HAW    = $clog2(HDEPTH);
  localparam int SW     = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int HW     = zsbr_pkg::HIST_W;
  localparam int CW     = zsbr_pkg::COEF_W;
  localparam int AW     = zsbr_pkg::ACC_W;
  localparam logic [5:0]    CDEPTH_IDX = 6'(CDEPTH);
  localparam logic [SW-1:0] LAST_SEC   = SW'(SECTIONS - 1);

  zsbr_pkg::seq_state_t state_r, state_nxt;

  logic [3:0]                ratio_r;
  logic [3:0]                pc_r;
  logic [2:0]                tp_r;
  logic [SW-1:0]             sec_r;
  logic [2:0]                st_r;
  logic signed [HW-1:0]      x_r;
  logic signed [HW-1:0]      h0_r;
  logic signed [HW-1:0]      h2_r;
  logic signed [zsbr_pkg::PROD_W-1:0] prod_r;
  logic signed [AW-1:0]      acc_r;
  logic signed [zsbr_pkg::SAMPLE_W-1:0] fs_r;
  logic signed [zsbr_pkg::SAMPLE_W:0]   t_r;
  logic                      out_valid_r;
  logic signed [zsbr_pkg::SAMPLE_W-1:0] out_fs_r;
  logic [zsbr_pkg::DAC_W-1:0] out_code_r;

  logic signed [CW-1:0]      coef_mem [CDEPTH];
  logic signed [HW-1:0]      hist_mem [HDEPTH];
  logic [CDEPTH-1:0]         coef_vld_r;
  logic [HDEPTH-1:0]         hist_vld_r;
  logic signed [CW-1:0]      coef_rd_r;
  logic signed [HW-1:0]      hist_rd_r;
  logic                      coef_rv_r;
  logic                      hist_rv_r;
  logic signed [CW-1:0]      coef_q;
  logic signed [HW-1:0]      hist_q;

  logic                      in_acc;
  logic                      tick_acc;
  logic                      load_acc;
  logic                      coef_we;
  logic [CAW-1:0]            coef_waddr;
  logic [CAW-1:0]            coef_raddr;
  logic [2:0]                coef_k;
  logic [1:0]                hist_rk;
  logic [HAW-1:0]            hist_raddr;
  logic                      hist_we;
  logic [1:0]                hist_wk;
  logic [HAW-1:0]            hist_waddr;
  logic signed [HW-1:0]      hist_wdata;
  logic signed [HW-1:0]      opnd;
  logic signed [AW-1:0]      scaled;
  logic signed [HW-1:0]      y_sat;
  logic [3:0]                pc_inc;
  logic                      take_table;
  logic signed [HW-1:0]      x_in;
  logic                      emit_go;
  logic signed [zsbr_pkg::SAMPLE_W-1:0] fs_nxt;
  logic [31:0]               q_prod;
  logic [13:0]               q5;
  logic [zsbr_pkg::DAC_W-1:0] code_nxt;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_filtered_sample = out_fs_r;
  assign out_dac_code = out_code_r;

  assign in_acc   = in_valid & in_ready;
  assign tick_acc = in_acc & (in_action == zsbr_pkg::ACTION_TICK);
  assign load_acc = in_acc & (in_action == zsbr_pkg::ACTION_LOAD);
  assign emit_go  = (state_r == zsbr_pkg::ST_EMIT) & (~out_valid_r | out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      zsbr_pkg::ST_IDLE: begin
        if (tick_acc) state_nxt = zsbr_pkg::ST_RUN;
      end
      zsbr_pkg::ST_RUN: begin
        if (st_r == 3'd7 && sec_r == LAST_SEC) state_nxt = zsbr_pkg::ST_FIN;
      end
      zsbr_pkg::ST_FIN: state_nxt = zsbr_pkg::ST_EMIT;
      zsbr_pkg::ST_EMIT: begin
        if (emit_go) state_nxt = zsbr_pkg::ST_IDLE;
      end
      default: state_nxt = zsbr_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready   = 1'b0;
    hist_we    = 1'b0;
    hist_wk    = 2'd0;
    hist_wdata = x_r;
    case (state_r)
      zsbr_pkg::ST_IDLE: in_ready = 1'b1;
      zsbr_pkg::ST_RUN: begin
        case (st_r)
          3'd3: begin
            hist_we    = 1'b1;
            hist_wk    = 2'd1;
            hist_wdata = h0_r;
          end
          3'd4: begin
            hist_we    = 1'b1;
            hist_wk    = 2'd0;
            hist_wdata = x_r;
          end
          3'd5: begin
            hist_we    = 1'b1;
            hist_wk    = 2'd3;
            hist_wdata = h2_r;
          end
          3'd7: begin
            hist_we    = 1'b1;
            hist_wk    = 2'd2;
            hist_wdata = y_sat;
          end
          default: hist_we = 1'b0;
        endcase
      end
      zsbr_pkg::ST_FIN:  in_ready = 1'b0;
      zsbr_pkg::ST_EMIT: in_ready = 1'b0;
      default:           in_ready = 1'b0;
    endcase
  end

  // addressing
  assign coef_k     = (st_r < 3'd5) ? st_r : 3'd0;
  assign coef_raddr = CAW'({sec_r, 2'b00}) + CAW'(sec_r) + CAW'(coef_k);
  assign hist_rk    = 2'(st_r - 3'd1);
  assign hist_raddr = HAW'({sec_r, hist_rk});
  assign hist_waddr = HAW'({sec_r, hist_wk});
  assign coef_we    = load_acc & (in_coef_index < CDEPTH_IDX);
  assign coef_waddr = CAW'(in_coef_index);

  assign coef_q = coef_rv_r ? coef_rd_r : '0;
  assign hist_q = hist_rv_r ? hist_rd_r : '0;
  assign opnd   = (st_r == 3'd1) ? x_r : hist_q;

  // floor scale to Q16.8, saturate to history width
  assign scaled = acc_r >>> zsbr_pkg::FRAC_SHIFT;
  always_comb begin
    if ((&scaled[AW-1:HW-1]) | ~(|scaled[AW-1:HW-1])) begin
      y_sat = scaled[HW-1:0];
    end else if (scaled[AW-1]) begin
      y_sat = {1'b1, {(HW-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(HW-1){1'b1}}};
    end
  end

  // tick source
  assign pc_inc     = pc_r + 4'd1;
  assign take_table = (pc_inc >= ratio_r);
  assign x_in       = take_table ? {zsbr_pkg::wave_lookup(tp_r), 8'b0} : '0;

  // output conversion
  assign fs_nxt = x_r[HW-1:8] + zsbr_pkg::SAMPLE_W'(x_r[HW-1] & (|x_r[7:0]));
  assign q_prod = 32'(t_r[zsbr_pkg::SAMPLE_W-1:0]) * 32'(zsbr_pkg::RECIP5);
  assign q5     = q_prod[31:zsbr_pkg::RECIP5_SH];
  always_comb begin
    if (t_r[zsbr_pkg::SAMPLE_W] || t_r == '0) begin
      code_nxt = '0;
    end else if (q5 > 14'(zsbr_pkg::DAC_MAX)) begin
      code_nxt = zsbr_pkg::DAC_MAX;
    end else begin
      code_nxt = q5[zsbr_pkg::DAC_W-1:0];
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (coef_we) coef_mem[coef_waddr] <= in_coef_value;
    coef_rd_r <= coef_mem[coef_raddr];
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    hist_rd_r <= hist_mem[hist_raddr];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= zsbr_pkg::ST_IDLE;
      ratio_r     <= 4'd6;
      pc_r        <= '0;
      tp_r        <= '0;
      sec_r       <= '0;
      st_r        <= '0;
      coef_vld_r  <= '0;
      hist_vld_r  <= '0;
      coef_rv_r   <= 1'b0;
      hist_rv_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      coef_rv_r <= coef_vld_r[coef_raddr];
      hist_rv_r <= hist_vld_r[hist_raddr];
      if (cfg_valid && cfg_ready) ratio_r <= cfg_data;
      if (coef_we) coef_vld_r[coef_waddr] <= 1'b1;
      if (hist_we) hist_vld_r[hist_waddr] <= 1'b1;
      if (tick_acc) begin
        pc_r  <= take_table ? 4'd0 : pc_inc;
        tp_r  <= take_table ? tp_r + 3'd1 : tp_r;
        sec_r <= '0;
        st_r  <= '0;
      end else if (state_r == zsbr_pkg::ST_RUN) begin
        st_r <= st_r + 3'd1;
        if (st_r == 3'd7 && sec_r != LAST_SEC) sec_r <= sec_r + SW'(1);
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (tick_acc) x_r <= x_in;
    if (state_r == zsbr_pkg::ST_RUN) begin
      if (st_r >= 3'd1 && st_r <= 3'd5) prod_r <= coef_q * opnd;
      if (st_r == 3'd2) acc_r <= AW'(prod_r);
      if (st_r >= 3'd3 && st_r <= 3'd6) acc_r <= acc_r + AW'(prod_r);
      if (st_r == 3'd2) h0_r <= hist_q;
      if (st_r == 3'd4) h2_r <= hist_q;
      if (st_r == 3'd7) x_r <= y_sat;
    end
    if (state_r == zsbr_pkg::ST_FIN) begin
      fs_r <= fs_nxt;
      t_r  <= {fs_nxt[zsbr_pkg::SAMPLE_W-1], fs_nxt} + zsbr_pkg::DAC_OFFSET;
    end
    if (emit_go) begin
      out_fs_r   <= fs_r;
      out_code_r <= code_nxt;
    end
  end

  // checks
  a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == zsbr_pkg::ST_EMIT))
    else $error("result word appeared outside the emit step");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    load_acc |=> !$rose(out_valid_r))
    else $error("coefficient load produced a result word");

  a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == zsbr_pkg::ST_RUN) |-> (sec_r <= LAST_SEC))
    else $error("section counter out of range");

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == zsbr_pkg::ST_RUN && st_r == 3'd7 && sec_r == LAST_SEC)
      |=> (state_r == zsbr_pkg::ST_FIN) ##1 (state_r == zsbr_pkg::ST_EMIT))
    else $error("cascade end did not lead to conversion");

endmodule
